// ===== rtl/core/zvh_pkg.sv =====
`timescale 1ns / 1ps
// zvh_pkg: shared types and constants of the zone valve and heater controller
// no dependencies

package zvh_pkg;

  // zone state machine codes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_ENABLE  = 2'd1;
  localparam logic [1:0] MODE_LAST    = 2'd2;
  localparam logic [1:0] MODE_DISABLE = 2'd3;

  // register indexes on the configuration port
  localparam logic REG_HEATER_ON_DELAY   = 1'b0;
  localparam logic REG_LAST_OFF_DELAY    = 1'b1;

  localparam int unsigned THERM_W = 12;
  localparam int unsigned DELAY_W = 16;

  localparam logic [DELAY_W-1:0] HEATER_ON_DELAY_RST = 16'd120;
  localparam logic [DELAY_W-1:0] LAST_OFF_DELAY_RST  = 16'd600;

  // one entry of the zone memory
  typedef struct packed {
    logic [1:0] mode;
    logic       demand;
  } zone_rec_t;

  localparam zone_rec_t ZONE_REC_RST = '{mode: MODE_IDLE, demand: 1'b0};

endpackage

// ===== rtl/core/zvh_zone_ram.sv =====
`timescale 1ns / 1ps
// zvh_zone_ram: per-zone record memory, one write and one registered read a cycle
// depends on zvh_pkg; entries never written read as the reset record

module zvh_zone_ram #(
  parameter int unsigned DEPTH = 12,
  parameter int unsigned AW    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  zvh_pkg::zone_rec_t wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output zvh_pkg::zone_rec_t rd_data
);
  import zvh_pkg::*;

  zone_rec_t        mem [DEPTH];
  logic [DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits stand in for the reset of the array
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : ZONE_REC_RST;
    end
  end

endmodule

// ===== rtl/core/zone_valve_heater_controller_top.sv =====
`timescale 1ns / 1ps
// zone_valve_heater_controller_top: tick sequencer, zone update and heater timer
// depends on zvh_pkg and zvh_zone_ram

// Each accepted beat is one tick of thermostat bits. The block walks the zones
// 0 to ZONES-1 through a small record memory (mode and latched demand per zone),
// reading one zone a cycle and writing its updated record back the cycle after;
// the zone memory has a single read port. The next tick is accepted once the
// result has left the working stage, even while the result beat still waits on
// m_tready. Valve commands, the demand count, the last-valve run and the heater
// timer are kept in flip-flops. Delay registers may be written only between
// ticks; a write takes effect at the next reload of the matching countdown.

module zone_valve_heater_controller_top #(
  parameter int unsigned ZONES = 12
) (
  input  logic        clk,
  input  logic        rst,
  // tick input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] thermostat_bits, [15:12] zero
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [11:0] valve_bits, [12] heater_on,
                                 // [13] last_run_active, [15:14] zero
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import zvh_pkg::*;

  localparam int unsigned ZW = $clog2(ZONES);
  localparam int unsigned CW = $clog2(ZONES + 1);
  localparam logic [ZW-1:0] LAST_ZONE = ZW'(ZONES - 1);

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ZONES = 2'd1;
  localparam logic [1:0] ST_HEAT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;

  // configuration
  logic [DELAY_W-1:0] heater_on_delay;
  logic [DELAY_W-1:0] last_off_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      heater_on_delay <= HEATER_ON_DELAY_RST;
      last_off_delay  <= LAST_OFF_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HEATER_ON_DELAY: heater_on_delay <= cfg_data;
        REG_LAST_OFF_DELAY:  last_off_delay  <= cfg_data;
        default: ;
      endcase
    end
  end

  // tick capture; zones beyond the thermostat field see no demand
  logic [THERM_W-1:0] therm;
  logic [ZONES-1:0]   therm_vec;

  for (genvar z = 0; z < ZONES; z++) begin : g_therm
    if (z < THERM_W) begin : g_in
      assign therm_vec[z] = therm[z];
    end else begin : g_none
      assign therm_vec[z] = 1'b0;
    end
  end

  logic s_fire;
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (s_fire) begin
      therm <= s_tdata[THERM_W-1:0];
    end
  end

  // read issue and process stage
  logic          issuing;
  logic [ZW-1:0] rd_idx;
  logic          p_valid;
  logic [ZW-1:0] p_idx;
  zone_rec_t     rec;
  zone_rec_t     rec_next;

  zvh_zone_ram #(
    .DEPTH (ZONES),
    .AW    (ZW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (p_valid),
    .wr_addr (p_idx),
    .wr_data (rec_next),
    .rd_en   (issuing),
    .rd_addr (rd_idx),
    .rd_data (rec)
  );

  // flip-flop state of the controller
  logic [ZONES-1:0]   valve_vec;
  logic [CW-1:0]      dem_cnt;
  logic               last_flag;
  logic [DELAY_W-1:0] last_cd;
  logic [DELAY_W-1:0] heater_cd;
  logic               heater_cmd;

  logic [ZONES-1:0]   valve_vec_next;
  logic [CW-1:0]      dem_cnt_next;
  logic               last_flag_next;
  logic [DELAY_W-1:0] last_cd_next;
  logic               on;

  // one zone step; the demand count register forwards each change to the
  // next zone, which is visited in the following cycle
  always_comb begin
    rec_next       = rec;
    valve_vec_next = valve_vec;
    dem_cnt_next   = dem_cnt;
    last_flag_next = last_flag;
    last_cd_next   = last_cd;
    on             = therm_vec[p_idx];
    unique case (rec.mode)
      MODE_IDLE: begin
        if (on) begin
          rec_next.mode  = MODE_ENABLE;
          last_flag_next = 1'b0;
        end else begin
          rec_next.mode = MODE_DISABLE;
        end
      end
      MODE_ENABLE: begin
        valve_vec_next[p_idx] = 1'b1;
        if (!rec.demand) begin
          dem_cnt_next = dem_cnt + CW'(1);
        end
        rec_next.demand = 1'b1;
        rec_next.mode   = MODE_IDLE;
      end
      MODE_LAST: begin
        // a new demand or a cancelled run ends the run at once
        if (!last_flag || on) begin
          if (!on) begin
            valve_vec_next[p_idx] = 1'b0;
          end
          last_cd_next   = last_off_delay;
          last_flag_next = 1'b0;
          rec_next.mode  = MODE_IDLE;
        end else if (last_cd == '0) begin
          last_cd_next          = last_off_delay;
          valve_vec_next[p_idx] = 1'b0;
          rec_next.mode         = MODE_IDLE;
          last_flag_next        = 1'b0;
        end else begin
          last_cd_next = last_cd - DELAY_W'(1);
        end
      end
      MODE_DISABLE: begin
        if (dem_cnt > CW'(1)) begin
          valve_vec_next[p_idx] = 1'b0;
          if (rec.demand) begin
            dem_cnt_next = dem_cnt - CW'(1);
          end
          rec_next.demand = 1'b0;
          rec_next.mode   = MODE_IDLE;
        end else if (rec.demand) begin
          // only demand left: hold this valve open for the off-delay run
          dem_cnt_next    = dem_cnt - CW'(1);
          rec_next.demand = 1'b0;
          rec_next.mode   = MODE_LAST;
          last_flag_next  = 1'b1;
        end else begin
          rec_next.mode = MODE_IDLE;
        end
      end
      default: ;
    endcase
  end

  // result register
  logic [THERM_W-1:0] valve_out;

  for (genvar b = 0; b < THERM_W; b++) begin : g_vout
    if (b < ZONES) begin : g_zone
      assign valve_out[b] = valve_vec[b];
    end else begin : g_pad
      assign valve_out[b] = 1'b0;
    end
  end

  logic out_free;
  assign out_free = !m_tvalid || m_tready;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      issuing <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            state   <= ST_ZONES;
            issuing <= 1'b1;
          end
        end
        ST_ZONES: begin
          p_valid <= issuing;
          if (issuing && rd_idx == LAST_ZONE) begin
            issuing <= 1'b0;
          end
          if (p_valid && p_idx == LAST_ZONE) begin
            state <= ST_HEAT;
          end
        end
        ST_HEAT: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      rd_idx <= '0;
    end else if (issuing) begin
      rd_idx <= rd_idx + ZW'(1);
    end
    if (issuing) begin
      p_idx <= rd_idx;
    end
  end

  // zone-level state and heater timer
  always_ff @(posedge clk) begin
    if (rst) begin
      valve_vec  <= '0;
      dem_cnt    <= '0;
      last_flag  <= 1'b0;
      last_cd    <= LAST_OFF_DELAY_RST;
      heater_cd  <= HEATER_ON_DELAY_RST;
      heater_cmd <= 1'b0;
    end else if (p_valid) begin
      valve_vec <= valve_vec_next;
      dem_cnt   <= dem_cnt_next;
      last_flag <= last_flag_next;
      last_cd   <= last_cd_next;
    end else if (state == ST_HEAT) begin
      priority if (dem_cnt == '0) begin
        heater_cmd <= 1'b0;
        heater_cd  <= heater_on_delay;
      end else if (heater_cd < DELAY_W'(2)) begin
        heater_cmd <= 1'b1;
        heater_cd  <= DELAY_W'(1);
      end else begin
        heater_cd <= heater_cd - DELAY_W'(1);
      end
    end
  end

  // output beat
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {2'b00, last_flag, heater_cmd, valve_out};
    end
  end

  // checks
  a_dem_cnt_range: assert property (@(posedge clk) disable iff (rst)
    dem_cnt <= CW'(ZONES))
    else $error("demand count above zone count");

  a_heater_cd_on: assert property (@(posedge clk) disable iff (rst)
    heater_cmd |-> heater_cd == DELAY_W'(1))
    else $error("heater on with countdown not held");

  a_proc_in_zones: assert property (@(posedge clk) disable iff (rst)
    (p_valid || issuing) |-> state == ST_ZONES)
    else $error("zone access outside zone walk");

  a_start_walk: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> issuing && rd_idx == '0)
    else $error("tick accepted without starting the zone walk");

endmodule
